>>> rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg - text console writer shared definitions
// Screen geometry, character codes, command encodings and the records that
// pass between the intake and the execution side of the console.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = ROWS * COLUMNS;

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CELL_W = 16;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;

	localparam int OPQ_DEPTH  = 2;
	localparam int RESQ_DEPTH = 2;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
	localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h02;
	localparam logic [CELL_W-1:0] BLANK_RESET  = {ATTR_RESET, SPACE_CODE};

	localparam logic CMD_PUT  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic REG_ATTR = 1'b0;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_WRITE,
		OP_READ
	} op_kind_t;

	typedef enum logic [1:0] {
		BK_INIT,
		BK_IDLE,
		BK_READ,
		BK_CLEAR
	} bk_state_t;

	typedef struct packed {
		op_kind_t          kind;
		logic              scroll;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [CELL_W-1:0] data;
		logic [COL_W-1:0]  cur_col;
		logic [ROW_W-1:0]  cur_row;
	} op_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_val;
		logic [COL_W-1:0]  cur_col;
		logic [ROW_W-1:0]  cur_row;
		logic              scrolled;
	} res_t;

endpackage

`default_nettype wire

>>> rtl/core/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram - generic single write, single read RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
	parameter int WIDTH = tcw_pkg::CELL_W,
	parameter int DEPTH = tcw_pkg::CELLS
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/core/tcw_fifo.sv
// ----------------------------------------------------------------------------
// tcw_fifo - small register queue
// Carries operation records from intake to execution, and results out.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = tcw_pkg::OPQ_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  full,
	output logic                  empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign push_ok = push & ~full;
	assign pop_ok  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front - console intake and cursor tracking
// Takes commands, advances the cursor, and classifies each beat into an
// operation record for the execution side.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             push,
	input  wire logic                             blocked,
	output logic                                  full,
	input  wire logic                             command,
	input  wire logic [tcw_pkg::CHAR_W-1:0]       char_code,
	input  wire logic [tcw_pkg::ROW_W-1:0]        read_row,
	input  wire logic [tcw_pkg::COL_W-1:0]        read_col,
	input  wire logic [tcw_pkg::ATTR_W-1:0]       attr,
	output logic                                  op_push,
	output tcw_pkg::op_t                          op
);

	localparam int COL_W = tcw_pkg::COL_W;
	localparam int ROW_W = tcw_pkg::ROW_W;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] nxt_col;
	logic [ROW_W-1:0] nxt_row;
	logic             wrap;
	logic             in_range;

	assign full    = blocked;
	assign op_push = push & ~blocked;

	assign in_range = ({1'b0, read_row} < (ROW_W + 1)'(tcw_pkg::ROWS)) &&
	                  ({1'b0, read_col} < (COL_W + 1)'(tcw_pkg::COLUMNS));

	always_comb begin
		nxt_col   = col_q;
		nxt_row   = row_q;
		wrap      = 1'b0;
		op.kind   = tcw_pkg::OP_NONE;
		op.scroll = 1'b0;
		op.row    = row_q;
		op.col    = col_q;
		op.data   = {attr, char_code};
		if (command == tcw_pkg::CMD_READ) begin
			op.row = read_row;
			op.col = read_col;
			if (in_range) begin
				op.kind = tcw_pkg::OP_READ;
			end
		end else if (char_code == tcw_pkg::NEWLINE_CODE) begin
			wrap = 1'b1;
		end else begin
			op.kind = tcw_pkg::OP_WRITE;
			if (col_q == COL_W'(tcw_pkg::COLUMNS - 1)) begin
				wrap = 1'b1;
			end else begin
				nxt_col = col_q + 1'b1;
			end
		end
		if (wrap) begin
			nxt_col = '0;
			if (row_q == ROW_W'(tcw_pkg::ROWS - 1)) begin
				op.scroll = 1'b1;
			end else begin
				nxt_row = row_q + 1'b1;
			end
		end
		op.cur_col = nxt_col;
		op.cur_row = nxt_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (op_push) begin
			col_q <= nxt_col;
			row_q <= nxt_row;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back - console execution and screen store
// Carries out cell writes and reads on a circular row store, advances the
// top row on a scroll and blanks the new bottom row one cell per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         op_valid,
	input  wire tcw_pkg::op_t op,
	output logic              op_pop,
	input  wire logic         res_full,
	output logic              res_push,
	output tcw_pkg::res_t     res,
	output logic              busy
);

	localparam int COL_W  = tcw_pkg::COL_W;
	localparam int ROW_W  = tcw_pkg::ROW_W;
	localparam int ADDR_W = tcw_pkg::ADDR_W;
	localparam int CELL_W = tcw_pkg::CELL_W;

	tcw_pkg::bk_state_t state_q, state_d;

	logic [ROW_W-1:0]  top_q, top_d;
	logic [ADDR_W-1:0] init_cnt_q, init_cnt_d;
	logic [COL_W-1:0]  clr_col_q, clr_col_d;
	logic [ADDR_W-1:0] clr_base_q, clr_base_d;
	logic [CELL_W-1:0] blank_q, blank_d;
	logic [COL_W-1:0]  rd_col_q, rd_col_d;
	logic [ROW_W-1:0]  rd_row_q, rd_row_d;

	logic [ROW_W:0]    row_sum;
	logic [ROW_W-1:0]  phys_row;
	logic [ADDR_W-1:0] op_addr;
	logic [ADDR_W-1:0] top_base;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [CELL_W-1:0] wdata;
	logic [CELL_W-1:0] rdata;

	assign row_sum  = {1'b0, top_q} + {1'b0, op.row};
	assign phys_row = (row_sum >= (ROW_W + 1)'(tcw_pkg::ROWS)) ?
	                  ROW_W'(row_sum - (ROW_W + 1)'(tcw_pkg::ROWS)) : row_sum[ROW_W-1:0];
	assign op_addr  = ADDR_W'(phys_row) * ADDR_W'(tcw_pkg::COLUMNS) + ADDR_W'(op.col);
	assign top_base = ADDR_W'(top_q) * ADDR_W'(tcw_pkg::COLUMNS);
	assign busy     = (state_q == tcw_pkg::BK_INIT);

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (tcw_pkg::CELLS)
	) u_screen (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (op_addr),
		.rdata (rdata)
	);

	always_comb begin
		state_d      = state_q;
		top_d        = top_q;
		init_cnt_d   = init_cnt_q;
		clr_col_d    = clr_col_q;
		clr_base_d   = clr_base_q;
		blank_d      = blank_q;
		rd_col_d     = rd_col_q;
		rd_row_d     = rd_row_q;
		op_pop       = 1'b0;
		res_push     = 1'b0;
		res.cell_val = '0;
		res.cur_col  = op.cur_col;
		res.cur_row  = op.cur_row;
		res.scrolled = op.scroll;
		we           = 1'b0;
		waddr        = op_addr;
		wdata        = op.data;
		unique case (state_q)
			tcw_pkg::BK_INIT: begin
				we         = 1'b1;
				waddr      = init_cnt_q;
				wdata      = tcw_pkg::BLANK_RESET;
				init_cnt_d = init_cnt_q + 1'b1;
				if (init_cnt_q == ADDR_W'(tcw_pkg::CELLS - 1)) begin
					state_d = tcw_pkg::BK_IDLE;
				end
			end
			tcw_pkg::BK_IDLE: begin
				if (op_valid && !res_full) begin
					op_pop = 1'b1;
					unique case (op.kind)
						tcw_pkg::OP_READ: begin
							rd_col_d = op.cur_col;
							rd_row_d = op.cur_row;
							state_d  = tcw_pkg::BK_READ;
						end
						tcw_pkg::OP_WRITE: begin
							we       = 1'b1;
							res_push = 1'b1;
						end
						default: begin
							res_push = 1'b1;
						end
					endcase
					if (op.scroll) begin
						clr_base_d = top_base;
						clr_col_d  = '0;
						blank_d    = {op.data[CELL_W-1:tcw_pkg::CHAR_W], tcw_pkg::SPACE_CODE};
						top_d      = (top_q == ROW_W'(tcw_pkg::ROWS - 1)) ? '0 : top_q + 1'b1;
						state_d    = tcw_pkg::BK_CLEAR;
					end
				end
			end
			tcw_pkg::BK_READ: begin
				res_push     = 1'b1;
				res.cell_val = rdata;
				res.cur_col  = rd_col_q;
				res.cur_row  = rd_row_q;
				res.scrolled = 1'b0;
				state_d      = tcw_pkg::BK_IDLE;
			end
			tcw_pkg::BK_CLEAR: begin
				we        = 1'b1;
				waddr     = clr_base_q + ADDR_W'(clr_col_q);
				wdata     = blank_q;
				clr_col_d = clr_col_q + 1'b1;
				if (clr_col_q == COL_W'(tcw_pkg::COLUMNS - 1)) begin
					state_d = tcw_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = tcw_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tcw_pkg::BK_INIT;
			top_q      <= '0;
			init_cnt_q <= '0;
			clr_col_q  <= '0;
		end else begin
			state_q    <= state_d;
			top_q      <= top_d;
			init_cnt_q <= init_cnt_d;
			clr_col_q  <= clr_col_d;
		end
	end

	always_ff @(posedge clk) begin
		clr_base_q <= clr_base_d;
		blank_q    <= blank_d;
		rd_col_q   <= rd_col_d;
		rd_row_q   <= rd_row_d;
	end

endmodule

`default_nettype wire

>>> rtl/core/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit - text-mode console engine, top level
// Cursor-driven character writer and cell reader over a scrolling
// 25 x 80 screen of 16-bit cells, with an APB attribute register.
//
//   channel   handshake              payload
//   -------   --------------------   ------------------------------------------
//   command   push / full            command, char_code, read_row, read_col
//   result    pop / empty            cell_data, cursor_col, cursor_row, scrolled
//   config    psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// A put is written as it leaves the queue; a read goes on to BK_READ for
// the registered RAM port. A scroll moves on to BK_CLEAR while the new
// bottom row is blanked through the single RAM write port. After reset full
// stays high while the store is blanked. Intake and
// execution are parted by a short queue; results wait in their own queue.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_unit #(
	parameter int OPQ_DEPTH  = tcw_pkg::OPQ_DEPTH,
	parameter int RESQ_DEPTH = tcw_pkg::RESQ_DEPTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic                         command,
	input  wire logic [tcw_pkg::CHAR_W-1:0]   char_code,
	input  wire logic [tcw_pkg::ROW_W-1:0]    read_row,
	input  wire logic [tcw_pkg::COL_W-1:0]    read_col,
	output logic                              empty,
	input  wire logic                         pop,
	output logic      [tcw_pkg::CELL_W-1:0]   cell_data,
	output logic      [tcw_pkg::COL_W-1:0]    cursor_col,
	output logic      [tcw_pkg::ROW_W-1:0]    cursor_row,
	output logic                              scrolled,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [2:0]                   paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready
);

	localparam int OP_W  = $bits(tcw_pkg::op_t);
	localparam int RES_W = $bits(tcw_pkg::res_t);

	logic [tcw_pkg::ATTR_W-1:0] attr_q;
	logic                       reg_wr;

	tcw_pkg::op_t  fe_op;
	tcw_pkg::op_t  be_op;
	tcw_pkg::res_t be_res;
	tcw_pkg::res_t out_res;
	logic [OP_W-1:0]  be_op_bits;
	logic [RES_W-1:0] out_res_bits;

	logic fe_push;
	logic opq_full;
	logic opq_empty;
	logic be_pop;
	logic be_busy;
	logic res_push;
	logic resq_full;

	assign pready = 1'b1;
	assign reg_wr = psel & penable & pwrite & pready & (paddr[2] == tcw_pkg::REG_ATTR);
	assign prdata = (paddr[2] == tcw_pkg::REG_ATTR) ? {24'b0, attr_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcw_pkg::ATTR_RESET;
		end else if (reg_wr) begin
			attr_q <= pwdata[tcw_pkg::ATTR_W-1:0];
		end
	end

	tcw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.blocked   (opq_full | be_busy),
		.full      (full),
		.command   (command),
		.char_code (char_code),
		.read_row  (read_row),
		.read_col  (read_col),
		.attr      (attr_q),
		.op_push   (fe_push),
		.op        (fe_op)
	);

	tcw_fifo #(
		.WIDTH (OP_W),
		.DEPTH (OPQ_DEPTH)
	) u_opq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fe_push),
		.wdata  (fe_op),
		.pop    (be_pop),
		.rdata  (be_op_bits),
		.full   (opq_full),
		.empty  (opq_empty)
	);

	assign be_op = tcw_pkg::op_t'(be_op_bits);

	tcw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (~opq_empty),
		.op       (be_op),
		.op_pop   (be_pop),
		.res_full (resq_full),
		.res_push (res_push),
		.res      (be_res),
		.busy     (be_busy)
	);

	tcw_fifo #(
		.WIDTH (RES_W),
		.DEPTH (RESQ_DEPTH)
	) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (be_res),
		.pop    (pop),
		.rdata  (out_res_bits),
		.full   (resq_full),
		.empty  (empty)
	);

	assign out_res    = tcw_pkg::res_t'(out_res_bits);
	assign cell_data  = out_res.cell_val;
	assign cursor_col = out_res.cur_col;
	assign cursor_row = out_res.cur_row;
	assign scrolled   = out_res.scrolled;

endmodule

`default_nettype wire
